FILE: hdl/ukbv_pkg.sv
// Shared types and constants for the unbounded knapsack best-value core.
package ukbv_pkg;

  // Field widths of the input and result words.
  localparam int WEIGHT_W = 10;
  localparam int VALUE_W  = 16;
  localparam int BEST_W   = 32;
  localparam int CAP_W    = 10;

  // Saturation ceiling of every table sum.
  localparam logic [BEST_W-1:0] TOP_VALUE = '1;

  // Register index, taken from address bit 2 of the configuration port.
  localparam logic REG_CAPACITY = 1'b0;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SWEEP,
    ST_FLUSH,
    ST_READ,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic start_sweep;
    logic step;
    logic rd_result;
    logic load_out;
    logic clear_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic at_cap;
    logic at_end;
    logic last;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/ukbv_ctrl.sv
// Controller state machine that sequences sweeps, result reads and table clears.
module ukbv_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ukbv_pkg::sts_t  sts,
  output logic            in_ready,
  output ukbv_pkg::cmd_t  cmd
);

  ukbv_pkg::state_t state;
  ukbv_pkg::state_t state_next;

  // State register; reset starts with a pass that clears the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ukbv_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ukbv_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.at_end) begin
          state_next = ukbv_pkg::ST_IDLE;
        end
      end
      ukbv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ukbv_pkg::ST_CHECK;
        end
      end
      ukbv_pkg::ST_CHECK: begin
        // A zero weight or one above the capacity leaves the table alone.
        if (!sts.skip) begin
          cmd.start_sweep = 1'b1;
          state_next      = ukbv_pkg::ST_SWEEP;
        end else if (sts.last) begin
          state_next = ukbv_pkg::ST_READ;
        end else begin
          state_next = ukbv_pkg::ST_IDLE;
        end
      end
      ukbv_pkg::ST_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.at_cap) begin
          state_next = ukbv_pkg::ST_FLUSH;
        end
      end
      ukbv_pkg::ST_FLUSH: begin
        // The last entry of the sweep is written in this cycle.
        if (sts.last) begin
          state_next = ukbv_pkg::ST_READ;
        end else begin
          state_next = ukbv_pkg::ST_IDLE;
        end
      end
      ukbv_pkg::ST_READ: begin
        cmd.rd_result = 1'b1;
        state_next    = ukbv_pkg::ST_RESULT;
      end
      ukbv_pkg::ST_RESULT: begin
        // Wait until the output register can take the word.
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ukbv_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_next = ukbv_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: hdl/ukbv_dp.sv
// Datapath: best-value table, sweep counter, saturating update stage and output register.
module ukbv_dp #(
  parameter int MAX_CAPACITY = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ukbv_pkg::cmd_t                 cmd,
  input  logic [ukbv_pkg::CAP_W-1:0]     capacity,
  input  logic [ukbv_pkg::WEIGHT_W-1:0]  item_weight,
  input  logic [ukbv_pkg::VALUE_W-1:0]   item_value,
  input  logic                           last_item,
  input  logic                           out_ready,
  output ukbv_pkg::sts_t                 sts,
  output logic                           out_valid,
  output logic [ukbv_pkg::BEST_W-1:0]    best_value,
  output logic                           saturated
);

  localparam int AW = $clog2(MAX_CAPACITY);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CAPACITY - 1);

  logic [ukbv_pkg::BEST_W-1:0]   mem [MAX_CAPACITY];

  logic [ukbv_pkg::WEIGHT_W-1:0] w_reg;
  logic [ukbv_pkg::VALUE_W-1:0]  v_reg;
  logic                          last_reg;

  logic [AW-1:0]                 cap;
  logic [AW-1:0]                 w_aw;
  logic [AW-1:0]                 cnt;
  logic [AW-1:0]                 rd_a_addr;
  logic [AW-1:0]                 rd_b_addr;
  logic [AW-1:0]                 s1_addr;
  logic [AW-1:0]                 wr_addr;
  logic [ukbv_pkg::BEST_W-1:0]   rd_a;
  logic [ukbv_pkg::BEST_W-1:0]   rd_b;
  logic [ukbv_pkg::BEST_W-1:0]   prev_wr;
  logic [ukbv_pkg::BEST_W-1:0]   opa;
  logic [ukbv_pkg::BEST_W-1:0]   cand;
  logic [ukbv_pkg::BEST_W-1:0]   new_best;
  logic [ukbv_pkg::BEST_W-1:0]   wr_data;
  logic [ukbv_pkg::BEST_W:0]     sum;
  logic                          s1_valid;
  logic                          s1_first;
  logic                          ovf;
  logic                          wr_en;
  logic                          w_is_one;

  // Capacity clamped to the last table entry.
  always_comb begin
    if (32'(capacity) > 32'(MAX_CAPACITY - 1)) begin
      cap = LAST_ADDR;
    end else begin
      cap = AW'(capacity);
    end
  end

  // Item checks and sweep addresses.
  assign w_aw      = AW'(w_reg);
  assign w_is_one  = (w_reg == ukbv_pkg::WEIGHT_W'(1));
  assign rd_a_addr = cnt - w_aw;
  assign rd_b_addr = cmd.rd_result ? cap : cnt;

  // Status toward the controller.
  assign sts.skip     = (w_reg == '0) || (32'(w_reg) > 32'(cap));
  assign sts.at_cap   = (cnt == cap);
  assign sts.at_end   = (cnt == LAST_ADDR);
  assign sts.last     = last_reg;
  assign sts.out_free = !out_valid || out_ready;

  // Update stage. With weight one the source entry was written on the
  // previous edge, too late for the read, so the written value is forwarded.
  always_comb begin
    opa = (w_is_one && !s1_first) ? prev_wr : rd_a;
    sum = {1'b0, opa} + (ukbv_pkg::BEST_W + 1)'(v_reg);
    if (sum[ukbv_pkg::BEST_W]) begin
      cand = ukbv_pkg::TOP_VALUE;
    end else begin
      cand = sum[ukbv_pkg::BEST_W-1:0];
    end
    new_best = (cand > rd_b) ? cand : rd_b;
  end

  // Single write port, shared by the clearing pass and the sweep.
  assign wr_en   = cmd.clear_step || s1_valid;
  assign wr_addr = cmd.clear_step ? cnt : s1_addr;
  assign wr_data = cmd.clear_step ? '0 : new_best;

  // Table memory with two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.step) begin
      rd_a <= mem[rd_a_addr];
    end
    if (cmd.step || cmd.rd_result) begin
      rd_b <= mem[rd_b_addr];
    end
  end

  // Control registers: counter, stage valid, overflow flag, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      s1_valid  <= 1'b0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.step;
      if (cmd.start_sweep) begin
        cnt <= w_aw;
      end else if (cmd.step || cmd.clear_step) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.load_out) begin
        cnt <= '0;
      end
      if (cmd.load_out) begin
        ovf <= 1'b0;
      end else if (s1_valid && sum[ukbv_pkg::BEST_W]) begin
        ovf <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      w_reg    <= item_weight;
      v_reg    <= item_value;
      last_reg <= last_item;
    end
    if (cmd.step) begin
      s1_addr  <= cnt;
      s1_first <= (cnt == w_aw);
    end
    if (s1_valid) begin
      prev_wr <= new_best;
    end
    if (cmd.load_out) begin
      best_value <= rd_b;
      saturated  <= ovf;
    end
  end

endmodule

FILE: hdl/unbounded_knapsack_best_value_core.sv
// Top level of the unbounded knapsack best-value core: register port, controller, datapath.
//
//   channel  direction  handshake               word
//   cfg      in         psel/penable/pready     capacity (address 0)
//   in       in         in_valid/in_ready       item_weight, item_value, last_item
//   out      out        out_valid/out_ready     best_value, saturated
//
// An item that takes part in the sweep holds the block from acceptance to the next
// acceptance while entries weight through cap are updated, one table entry per cycle
// through the single write port; an ignored item only passes the check state.
// A last item adds a result read, then a clearing pass over all MAX_CAPACITY table
// entries, which also runs after reset; no item is taken meanwhile.
// A stalled result waits in the output register while the block goes on.
module unbounded_knapsack_best_value_core #(
  parameter int MAX_CAPACITY = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ukbv_pkg::WEIGHT_W-1:0]  item_weight,
  input  logic [ukbv_pkg::VALUE_W-1:0]   item_value,
  input  logic                           last_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ukbv_pkg::BEST_W-1:0]    best_value,
  output logic                           saturated
);

  logic [ukbv_pkg::CAP_W-1:0] capacity;
  ukbv_pkg::cmd_t             cmd;
  ukbv_pkg::sts_t             sts;

  // Register port; address bit 2 selects the register word.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ukbv_pkg::REG_CAPACITY) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == ukbv_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[ukbv_pkg::CAP_W-1:0];
    end
  end

  // Controller.
  ukbv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath.
  ukbv_dp #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .capacity    (capacity),
    .item_weight (item_weight),
    .item_value  (item_value),
    .last_item   (last_item),
    .out_ready   (out_ready),
    .sts         (sts),
    .out_valid   (out_valid),
    .best_value  (best_value),
    .saturated   (saturated)
  );

`ifndef SYNTHESIS
  // One item at a time: the cycle after an acceptance takes nothing.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while the previous word is still in work");

  // A result word never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken word");

  // The table clearing pass follows reset before any item is taken.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("item accepted before the table was cleared");

  // Sweep steps and clearing writes never share a cycle.
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && cmd.clear_step))
    else $error("sweep and clear both drive the table");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the unbounded knapsack best-value core.
`timescale 1ns / 100ps

module tb;

  localparam int MAX_CAP = 1024;
  localparam int PLAN_ROWS = 19;
  localparam int RANDOM_ITEMS = 560;
  // Longer than one full sweep or one clearing pass, with margin.
  localparam int SETTLE_CYCLES = 1200;
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_PHASE = 3;
  localparam longint LIMIT_CYCLES = 5_000_000;
  localparam logic [2:0] CAPACITY_ADDR = {ukbv_pkg::REG_CAPACITY, 2'b00};

  // One result word as the block reports it.
  typedef struct packed {
    logic [ukbv_pkg::BEST_W-1:0] best;
    logic                        sat;
  } answer_t;

  // One directed step: an optional capacity write, then one item word.
  typedef struct packed {
    logic                          set_cap;
    logic [ukbv_pkg::CAP_W-1:0]    cap;
    logic [ukbv_pkg::WEIGHT_W-1:0] wt;
    logic [ukbv_pkg::VALUE_W-1:0]  val;
    logic                          fin;
    logic                          typed;
    logic [ukbv_pkg::BEST_W-1:0]   best;
    logic                          sat;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [2:0]                    paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ukbv_pkg::WEIGHT_W-1:0] item_weight = '0;
  logic [ukbv_pkg::VALUE_W-1:0]  item_value = '0;
  logic                          last_item = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [ukbv_pkg::BEST_W-1:0]   best_value;
  logic                          saturated;
  logic                          hold_off_req = 1'b0;

  // Predictor state: best value per capacity, clamp flag, capacity setting.
  logic [ukbv_pkg::BEST_W-1:0] best_tbl [MAX_CAP];
  logic                        clamp_seen = 1'b0;
  logic [ukbv_pkg::CAP_W-1:0]  cap_setting = '0;

  answer_t answers_due [$];
  int      fail_count = 0;

  // Directed steps; rows with a typed answer can be checked by hand.
  plan_row_t opening_plan [PLAN_ROWS] = '{
    // Zero weight with the last mark still reports, at capacity zero.
    '{1'b0, 10'd0,    10'd0,    16'd5,     1'b1, 1'b1, 32'd0,        1'b0},
    // Weight above capacity leaves the table alone.
    '{1'b0, 10'd0,    10'd1,    16'd65535, 1'b1, 1'b1, 32'd0,        1'b0},
    // Largest capacity filled with the lightest, most valuable item.
    '{1'b1, 10'd1023, 10'd1,    16'd65535, 1'b1, 1'b1, 32'd67042305, 1'b0},
    '{1'b0, 10'd0,    10'd1023, 16'd1,     1'b1, 1'b1, 32'd1,        1'b0},
    // Heaviest item, an ignored one, then one that cannot improve the top.
    '{1'b0, 10'd0,    10'd1023, 16'd65535, 1'b0, 1'b0, 32'd0,        1'b0},
    '{1'b0, 10'd0,    10'd0,    16'd65535, 1'b0, 1'b0, 32'd0,        1'b0},
    '{1'b0, 10'd0,    10'd512,  16'd7,     1'b1, 1'b1, 32'd65535,    1'b0},
    // Weight just above, then equal to the capacity.
    '{1'b1, 10'd1000, 10'd1001, 16'd9,     1'b1, 1'b1, 32'd0,        1'b0},
    '{1'b0, 10'd0,    10'd1000, 16'd65535, 1'b1, 1'b1, 32'd65535,    1'b0},
    // Capacity raised in the middle of a problem.
    '{1'b1, 10'd10,   10'd3,    16'd4,     1'b0, 1'b0, 32'd0,        1'b0},
    '{1'b0, 10'd0,    10'd5,    16'd7,     1'b0, 1'b0, 32'd0,        1'b0},
    '{1'b1, 10'd20,   10'd2,    16'd3,     1'b1, 1'b0, 32'd0,        1'b0},
    // The last mark on a zero-weight item closes an open problem.
    '{1'b1, 10'd7,    10'd7,    16'd100,   1'b0, 1'b0, 32'd0,        1'b0},
    '{1'b0, 10'd0,    10'd0,    16'd0,     1'b1, 1'b1, 32'd100,      1'b0},
    // Zero value.
    '{1'b0, 10'd0,    10'd1,    16'd0,     1'b1, 1'b1, 32'd0,        1'b0},
    // Mixed kinds where the best choice repeats one of them.
    '{1'b1, 10'd12,   10'd4,    16'd9,     1'b0, 1'b0, 32'd0,        1'b0},
    '{1'b0, 10'd0,    10'd6,    16'd14,    1'b0, 1'b0, 32'd0,        1'b0},
    '{1'b0, 10'd0,    10'd5,    16'd11,    1'b1, 1'b0, 32'd0,        1'b0},
    '{1'b0, 10'd0,    10'd1,    16'd65535, 1'b1, 1'b1, 32'd786420,   1'b0}
  };

  unbounded_knapsack_best_value_core #(
    .MAX_CAPACITY(MAX_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .item_weight(item_weight),
    .item_value(item_value),
    .last_item(last_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .best_value(best_value),
    .saturated(saturated)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fold one item kind into the predicted table; returns 1 when it reports.
  function automatic logic fold_item(input logic [ukbv_pkg::WEIGHT_W-1:0] wt,
                                     input logic [ukbv_pkg::VALUE_W-1:0] val,
                                     input logic fin, output answer_t ans);
    int                          cap;
    logic [ukbv_pkg::BEST_W:0]   sum;
    logic [ukbv_pkg::BEST_W-1:0] cand;
    cap = int'(cap_setting);
    if (cap > MAX_CAP - 1) begin
      cap = MAX_CAP - 1;
    end
    if (wt != '0 && int'(wt) <= cap) begin
      for (int c = int'(wt); c <= cap; c++) begin
        sum = {1'b0, best_tbl[c - int'(wt)]} + val;
        if (sum > {1'b0, ukbv_pkg::TOP_VALUE}) begin
          cand = ukbv_pkg::TOP_VALUE;
          clamp_seen = 1'b1;
        end else begin
          cand = sum[ukbv_pkg::BEST_W-1:0];
        end
        if (cand > best_tbl[c]) begin
          best_tbl[c] = cand;
        end
      end
    end
    ans.best = best_tbl[cap];
    ans.sat = clamp_seen;
    if (fin) begin
      foreach (best_tbl[i]) best_tbl[i] = '0;
      clamp_seen = 1'b0;
    end
    return fin;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Present one item word, predict at acceptance, then idle for the gap.
  task automatic send_word(input logic [ukbv_pkg::WEIGHT_W-1:0] wt,
                           input logic [ukbv_pkg::VALUE_W-1:0] val,
                           input logic fin, input logic typed, input answer_t typed_ans,
                           input int gap);
    answer_t ans;
    in_valid <= 1'b1;
    item_weight <= wt;
    item_value <= val;
    last_item <= fin;
    do @(posedge clk); while (!in_ready);
    if (fold_item(wt, val, fin, ans)) begin
      answers_due.push_back(typed ? typed_ans : ans);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all results, let the block finish its sweep and clear, then write.
  task automatic write_capacity(input logic [ukbv_pkg::CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= {{(32 - ukbv_pkg::CAP_W){1'b0}}, cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_setting = cap;
  endtask

  function automatic int sender_gap(input bit no_gaps);
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 200);
  endfunction

  // Sender: reset, directed steps, random problems, then drain and report.
  initial begin : item_source
    int                            phase;
    int                            problems;
    int                            kinds;
    int                            r;
    int                            counted;
    int                            cap;
    bit                            no_gaps;
    bit                            open_problem;
    logic [ukbv_pkg::WEIGHT_W-1:0] wt;
    logic [ukbv_pkg::VALUE_W-1:0]  val;
    logic                          fin;
    answer_t                       typed_ans;
    foreach (best_tbl[i]) best_tbl[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    foreach (opening_plan[i]) begin
      if (opening_plan[i].set_cap) begin
        write_capacity(opening_plan[i].cap);
      end
      typed_ans.best = opening_plan[i].best;
      typed_ans.sat = opening_plan[i].sat;
      send_word(opening_plan[i].wt, opening_plan[i].val, opening_plan[i].fin,
                opening_plan[i].typed, typed_ans, sender_gap(1'b0));
    end

    // Random part: phases of well-formed problems at one capacity each.
    counted = 0;
    phase = 0;
    open_problem = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      phase++;
      r = $urandom_range(0, 99);
      if (phase == HOLD_PHASE) cap = $urandom_range(4, 30);
      else if (r < 4) cap = 0;
      else if (r < 7) cap = 1023;
      else if (r < 12) cap = $urandom_range(256, 1022);
      else if (r < 30) cap = $urandom_range(64, 255);
      else cap = $urandom_range(1, 63);
      write_capacity(cap[ukbv_pkg::CAP_W-1:0]);
      no_gaps = ($urandom_range(0, 3) == 0);
      problems = (cap > 255) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      // Results pile up behind a stalled receiver in this phase.
      if (phase == HOLD_PHASE) begin
        hold_off_req <= 1'b1;
        no_gaps = 1'b1;
        problems = 8;
      end
      for (int p = 0; p < problems; p++) begin
        kinds = $urandom_range(1, 6);
        for (int k = 0; k < kinds; k++) begin
          r = $urandom_range(0, 99);
          if (r < 8) wt = '0;
          else if (r < 15) wt = (ukbv_pkg::WEIGHT_W)'($urandom_range(0, 1023));
          else if (r < 22 && cap < 1023) begin
            wt = (ukbv_pkg::WEIGHT_W)'($urandom_range(cap + 1, 1023));
          end
          else if (cap == 0) wt = (ukbv_pkg::WEIGHT_W)'($urandom_range(1, 1023));
          else wt = (ukbv_pkg::WEIGHT_W)'($urandom_range(1, cap));
          r = $urandom_range(0, 99);
          if (r < 5) val = '0;
          else if (r < 10) val = '1;
          else val = (ukbv_pkg::VALUE_W)'($urandom_range(0, 65535));
          fin = (k == kinds - 1) || ($urandom_range(0, 99) < 3);
          // Now and then a problem stays open across a capacity change.
          if (p == problems - 1 && k == kinds - 1 && $urandom_range(0, 3) == 0) begin
            fin = 1'b0;
          end
          send_word(wt, val, fin, 1'b0, '0, sender_gap(no_gaps));
          open_problem = !fin;
          counted++;
          if (fin) break;
        end
      end
    end
    if (open_problem) begin
      send_word((ukbv_pkg::WEIGHT_W)'($urandom_range(1, 1023)),
                (ukbv_pkg::VALUE_W)'($urandom_range(0, 65535)), 1'b1, 1'b0, '0, 0);
    end

    // Drain and let any trailing activity settle.
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("[unbounded_knapsack_best_value_core] OK");
    end else begin
      $display("[unbounded_knapsack_best_value_core] ERROR");
    end
    $finish;
  end

  // Receiver: random ready runs and stalls, plus one long hold-off.
  initial begin : result_sink
    int run_len;
    int stall_len;
    bit hold_taken;
    hold_taken = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40) : $urandom_range(100, 400);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = $urandom_range(0, 99);
      if (stall_len < 70) stall_len = 0;
      else if (stall_len < 95) stall_len = $urandom_range(1, 4);
      else stall_len = $urandom_range(20, 300);
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Compare every accepted result word with the oldest expected one.
  always @(posedge clk) begin
    answer_t due;
    if (!rst && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        log_failure($sformatf("result word with none expected: best_value %0d saturated %0b",
                              best_value, saturated));
      end else begin
        due = answers_due.pop_front();
        if (best_value !== due.best) begin
          log_failure($sformatf("best_value mismatch: expected %0d, got %0d",
                                due.best, best_value));
        end
        if (saturated !== due.sat) begin
          log_failure($sformatf("saturated mismatch: expected %0b, got %0b",
                                due.sat, saturated));
        end
      end
    end
  end

  // Hang guard.
  initial begin : watchdog
    #(LIMIT_CYCLES * 8);
    $display("[unbounded_knapsack_best_value_core] ERROR");
    $finish;
  end

endmodule
